// ===== hw/rtl/bbf_pkg.sv =====
package bbf_pkg;

    // fixed point layout
    localparam int COEF_FRAC_BITS = 16;
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 18;
    localparam int GAIN_W         = 12;
    localparam int Y_W            = 32;
    localparam int DIFF_W         = SAMPLE_W + 1;
    localparam int PROD_W         = COEF_W + Y_W;
    localparam int ACC_W          = 60;
    localparam int YS_W           = ACC_W - COEF_FRAC_BITS;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int Q_W            = PROD_W - GAIN_FRAC_BITS;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = COEF_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN = 2'd3;

    // register reset values
    localparam logic signed [COEF_W-1:0] RST_COEF_B0  = 18'sd10425;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1  = -18'sd98209;
    localparam logic signed [COEF_W-1:0] RST_COEF_A2  = 18'sd44686;
    localparam logic [GAIN_W-1:0]        RST_OUT_GAIN = 12'd640;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_B0,
        MUL_A1,
        MUL_A2,
        MUL_GAIN
    } t_mul_sel;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } t_acc_op;

    typedef struct packed {
        logic     accept;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     upd_hist;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/bbf_in_if.sv =====
interface bbf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bbf_pkg::SAMPLE_W-1:0] sample_in;
    logic                                start_of_block;

    modport source (output valid, output sample_in, output start_of_block, input ready);
    modport sink   (input valid, input sample_in, input start_of_block, output ready);
endinterface

// ===== hw/rtl/bbf_out_if.sv =====
interface bbf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bbf_pkg::SAMPLE_W-1:0] sample_out;
    logic                                clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== hw/rtl/biquad_bandpass_filter_top.sv =====
// Band-pass biquad in direct form I for signed 16-bit samples: y = b0*(x - x[n-2])
// - a1*y[n-1] - a2*y[n-2], with Q2.16 coefficients, Q24.8 output history, then an
// unsigned Q4.8 gain, truncation toward zero and saturation to 16 bits with a clip
// flag. A start_of_block flag clears the history before its sample is filtered.
// One 18x32 multiplier is shared by the four products of a sample, so no new
// sample is taken until the last result is loaded into the output register, a load
// that waits while the register is held by the sink. The next sample may be taken
// while a result waits in the output register. Coefficient writes must only be made
// while no sample is in flight; they apply to the samples that follow.
module biquad_bandpass_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bbf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    bbf_in_if.sink                            i_in,
    bbf_out_if.source                         o_out
);
    import bbf_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // sequencer
    bbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    bbf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample_in      (i_in.sample_in),
        .i_start_of_block (i_in.start_of_block),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_sample_out     (o_out.sample_out),
        .o_clipped        (o_out.clipped),
        .i_cmd            (cmd),
        .o_status         (status)
    );

    assign i_in.ready = in_ready;

`ifndef SYNTHESIS
    // one sample in flight: no input transfer right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a sample is in flight");

    // a result only appears after the sequencer loads it
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(cmd.load_out))
        else $error("output valid without a load");

    // the output register is never overwritten while it is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("result loaded over a pending one");
`endif

endmodule

// ===== hw/rtl/bbf_ctrl.sv =====
module bbf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bbf_pkg::t_dp_status i_status,
    output bbf_pkg::t_dp_cmd    o_cmd
);
    import bbf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_B0,
        S_A1,
        S_A2,
        S_SUM,
        S_UPD,
        S_GAIN,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    // command decode and next state
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.accept     = 1'b0;
        o_cmd.mul_sel    = MUL_NONE;
        o_cmd.acc_op     = ACC_HOLD;
        o_cmd.upd_hist   = 1'b0;
        o_cmd.load_out   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_B0;
                end
            end
            S_B0: begin
                o_cmd.mul_sel = MUL_B0;
                n_state       = S_A1;
            end
            S_A1: begin
                o_cmd.mul_sel = MUL_A1;
                o_cmd.acc_op  = ACC_LOAD;
                n_state       = S_A2;
            end
            S_A2: begin
                o_cmd.mul_sel = MUL_A2;
                o_cmd.acc_op  = ACC_SUB;
                n_state       = S_SUM;
            end
            S_SUM: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_hist = 1'b1;
                n_state        = S_GAIN;
            end
            S_GAIN: begin
                o_cmd.mul_sel = MUL_GAIN;
                n_state       = S_OUT;
            end
            S_OUT: begin
                o_cmd.load_out = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/bbf_dp.sv =====
module bbf_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bbf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [bbf_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic                                i_start_of_block,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [bbf_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_clipped,
    input  bbf_pkg::t_dp_cmd                    i_cmd,
    output bbf_pkg::t_dp_status                 o_status
);
    import bbf_pkg::*;

    localparam logic signed [YS_W-1:0] Y_MAX = {{(YS_W-Y_W){1'b0}}, 1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [YS_W-1:0] Y_MIN = {{(YS_W-Y_W){1'b1}}, 1'b1, {(Y_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

    // configuration registers
    logic signed [COEF_W-1:0] r_coef_b0;
    logic signed [COEF_W-1:0] r_coef_a1;
    logic signed [COEF_W-1:0] r_coef_a2;
    logic [GAIN_W-1:0]        r_out_gain;

    // history and working registers
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [SAMPLE_W-1:0] r_in1;
    logic signed [SAMPLE_W-1:0] r_in2;
    logic signed [Y_W-1:0]      r_y1;
    logic signed [Y_W-1:0]      r_y2;
    logic signed [Y_W-1:0]      r_y;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_sample_out;
    logic                       r_clipped;

    logic signed [DIFF_W-1:0] diff;
    logic signed [COEF_W-1:0] op_a;
    logic signed [Y_W-1:0]    op_b;
    logic signed [PROD_W-1:0] mul;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [YS_W-1:0]   y_sh;
    logic signed [Y_W-1:0]    y_sat;
    logic signed [PROD_W-1:0] prod_biased;
    logic signed [Q_W-1:0]    q_full;
    logic signed [SAMPLE_W-1:0] q_sat;
    logic                     q_clip;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_b0  <= RST_COEF_B0;
            r_coef_a1  <= RST_COEF_A1;
            r_coef_a2  <= RST_COEF_A2;
            r_out_gain <= RST_OUT_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_B0:  r_coef_b0  <= i_cfg_data;
                REG_COEF_A1:  r_coef_a1  <= i_cfg_data;
                REG_COEF_A2:  r_coef_a2  <= i_cfg_data;
                REG_OUT_GAIN: r_out_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // feedforward difference x - x[n-2]
    assign diff = {r_x[SAMPLE_W-1], r_x} - {r_in2[SAMPLE_W-1], r_in2};

    // shared multiplier operand select
    always_comb begin
        op_a = r_coef_b0;
        op_b = {{(Y_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        unique case (i_cmd.mul_sel)
            MUL_A1: begin
                op_a = r_coef_a1;
                op_b = r_y1;
            end
            MUL_A2: begin
                op_a = r_coef_a2;
                op_b = r_y2;
            end
            MUL_GAIN: begin
                op_a = {{(COEF_W-GAIN_W){1'b0}}, r_out_gain};
                op_b = r_y;
            end
            default: ;
        endcase
    end

    assign mul      = op_a * op_b;
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // round to Q24.8 and saturate to 32 bits
    assign y_sh = r_acc[ACC_W-1:COEF_FRAC_BITS];
    always_comb begin
        if (y_sh > Y_MAX) begin
            y_sat = Y_MAX[Y_W-1:0];
        end else if (y_sh < Y_MIN) begin
            y_sat = Y_MIN[Y_W-1:0];
        end else begin
            y_sat = y_sh[Y_W-1:0];
        end
    end

    // gain product truncated toward zero, then saturated to 16 bits
    assign prod_biased = r_prod + (r_prod[PROD_W-1] ?
                         PROD_W'((1 << GAIN_FRAC_BITS) - 1) : PROD_W'(0));
    assign q_full = prod_biased[PROD_W-1:GAIN_FRAC_BITS];
    always_comb begin
        q_clip = 1'b0;
        if (q_full > Q_MAX) begin
            q_sat  = Q_MAX[SAMPLE_W-1:0];
            q_clip = 1'b1;
        end else if (q_full < Q_MIN) begin
            q_sat  = Q_MIN[SAMPLE_W-1:0];
            q_clip = 1'b1;
        end else begin
            q_sat = q_full[SAMPLE_W-1:0];
        end
    end

    // sample capture and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x   <= '0;
            r_in1 <= '0;
            r_in2 <= '0;
            r_y1  <= '0;
            r_y2  <= '0;
            r_y   <= '0;
        end else if (i_cmd.accept) begin
            r_x <= i_sample_in;
            if (i_start_of_block) begin
                r_in1 <= '0;
                r_in2 <= '0;
                r_y1  <= '0;
                r_y2  <= '0;
            end
        end else if (i_cmd.upd_hist) begin
            r_in2 <= r_in1;
            r_in1 <= r_x;
            r_y2  <= r_y1;
            r_y1  <= y_sat;
            r_y   <= y_sat;
        end
    end

    // product register and accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul;
        end
        unique case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= (prod_ext <<< 8) + ROUND_HALF;
            ACC_SUB:  r_acc <= r_acc - prod_ext;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_sample_out <= q_sat;
            r_clipped    <= q_clip;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample_out      = r_sample_out;
    assign o_clipped         = r_clipped;

endmodule

// ===== tb/biquad_output_checker.sv =====
module biquad_output_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bbf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bbf_in_if                              i_in_ch,
    bbf_out_if                             i_out_ch,
    output int                             o_err_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bbf_pkg::*;

    // saturation bounds of the stored filter output and of the output sample
    localparam longint Y_MAX       = (longint'(1) <<< (Y_W - 1)) - 1;
    localparam longint Y_MIN       = -(longint'(1) <<< (Y_W - 1));
    localparam longint OUT_MAX     = 32767;
    localparam longint OUT_MIN     = -32768;
    localparam int     SHOWN_LIMIT = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } t_filter_out;

    t_filter_out expected_outputs[$];

    // mirrored coefficient registers
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [GAIN_W-1:0]        gain;

    // filter history: inputs as integers, outputs in Q24.8
    logic signed [SAMPLE_W-1:0] x_d1;
    logic signed [SAMPLE_W-1:0] x_d2;
    logic signed [Y_W-1:0]      y_d1;
    logic signed [Y_W-1:0]      y_d2;

    int mismatches;
    int results_seen;

    // one sample through the biquad, advancing the history
    function automatic t_filter_out filter_sample(input logic signed [SAMPLE_W-1:0] x,
                                                  input logic clear);
        longint      acc;
        longint      y;
        longint      scaled;
        longint      q;
        t_filter_out r;
        if (clear) begin
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
        end
        // exact sum with COEF_FRAC_BITS+8 fraction bits, then round half up
        acc = longint'(b0) * (longint'(x) - longint'(x_d2)) * 256;
        acc = acc - longint'(a1) * longint'(y_d1) - longint'(a2) * longint'(y_d2);
        acc = acc + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        y = acc >>> COEF_FRAC_BITS;
        if (y > Y_MAX) y = Y_MAX;
        if (y < Y_MIN) y = Y_MIN;
        x_d2 = x_d1;
        x_d1 = x;
        y_d2 = y_d1;
        y_d1 = y[Y_W-1:0];
        // gain, truncate toward zero, saturate to 16 bits
        scaled = y * longint'(gain);
        q = scaled / (longint'(1) <<< GAIN_FRAC_BITS);
        r.clipped = 1'b0;
        if (q > OUT_MAX) begin
            q = OUT_MAX;
            r.clipped = 1'b1;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
            r.clipped = 1'b1;
        end
        r.sample = q[SAMPLE_W-1:0];
        return r;
    endfunction

    // watch config writes and both channels at the rising edge
    always @(posedge i_clk) begin
        t_filter_out got;
        t_filter_out want;
        if (!i_rst_n) begin
            b0   = RST_COEF_B0;
            a1   = RST_COEF_A1;
            a2   = RST_COEF_A2;
            gain = RST_OUT_GAIN;
            x_d1 = '0;
            x_d2 = '0;
            y_d1 = '0;
            y_d2 = '0;
            mismatches   = 0;
            results_seen = 0;
            expected_outputs.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COEF_B0: begin
                        b0 = i_cfg_data;
                    end
                    REG_COEF_A1: begin
                        a1 = i_cfg_data;
                    end
                    REG_COEF_A2: begin
                        a2 = i_cfg_data;
                    end
                    REG_OUT_GAIN: begin
                        gain = i_cfg_data[GAIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // input transfer: predict its result
            if (i_in_ch.valid && i_in_ch.ready) begin
                want = filter_sample(i_in_ch.sample_in, i_in_ch.start_of_block);
                expected_outputs = {expected_outputs, want};
            end
            // output transfer: compare with the oldest prediction
            if (i_out_ch.valid && i_out_ch.ready) begin
                got.sample  = i_out_ch.sample_out;
                got.clipped = i_out_ch.clipped;
                if (expected_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_LIMIT) begin
                        $display("result %0d: none expected, got sample_out %0d clipped %0b",
                                 results_seen, got.sample, got.clipped);
                    end
                end else begin
                    want = expected_outputs.pop_front();
                    if (got.sample !== want.sample || got.clipped !== want.clipped) begin
                        mismatches++;
                        if (mismatches <= SHOWN_LIMIT) begin
                            $display({"result %0d: expected sample_out %0d clipped %0b,",
                                      " got sample_out %0d clipped %0b"},
                                     results_seen, want.sample, want.clipped,
                                     got.sample, got.clipped);
                        end
                    end
                end
                results_seen++;
            end
        end
        o_pending   <= expected_outputs.size();
        o_err_count <= mismatches;
    end

endmodule

// ===== tb/tb_biquad_bandpass_filter_top.sv =====
module tb_biquad_bandpass_filter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 320;
    localparam int TAIL_CYCLES    = 24;
    localparam int COEF_MAX       = 131071;
    localparam int COEF_MIN       = -131072;
    localparam int GAIN_MAX       = 4095;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int err_count;
    int pending;
    int sent_count = 0;
    int stall_cycles = 0;
    bit calm = 1'b0;

    bbf_in_if  in_ch ();
    bbf_out_if out_ch ();

    always #6ns clk = ~clk;

    biquad_bandpass_filter_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    biquad_output_checker checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_ch     (in_ch),
        .i_out_ch    (out_ch),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // mix of extremes, small signals and full-range noise
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            case ($urandom_range(0, 3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return '0;
                default: return '1;
            endcase
        end else if (pick < 50) begin
            return SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
        end
        return SAMPLE_W'($urandom());
    endfunction

    function automatic logic pick_start();
        return $urandom_range(0, 99) < 4;
    endfunction

    // offer one sample, entered and left at a falling edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic sob);
        if (!calm && $urandom_range(0, 99) < 15) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.sample_in      <= x;
        in_ch.start_of_block <= sob;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sent_count++;
        @(negedge clk);
    endtask

    // stop offering and wait until every result has come back
    task automatic drain_filter();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    // gain goes in with junk in the unused upper bits
    task automatic program_filter(input int b0, input int a1, input int a2, input int gain);
        write_reg(REG_COEF_B0, CFG_DATA_W'(b0));
        write_reg(REG_COEF_A1, CFG_DATA_W'(a1));
        write_reg(REG_COEF_A2, CFG_DATA_W'(a2));
        write_reg(REG_OUT_GAIN, {(CFG_DATA_W - GAIN_W)'($urandom()), GAIN_W'(gain)});
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int b0, input int a1, input int a2, input int gain,
                             input int count);
        drain_filter();
        program_filter(b0, a1, a2, gain);
        repeat (count) send_sample(pick_sample(), pick_start());
    endtask

    // random coefficients inside the stability triangle
    task automatic run_stable_phase(input int count);
        int a1;
        int a2;
        int span;
        a2   = int'($urandom_range(0, 120000)) - 60000;
        span = 65536 + a2 - 2000;
        a1   = int'($urandom_range(0, 2 * span)) - span;
        run_phase(int'($urandom_range(0, 40000)) - 20000, a1, a2,
                  $urandom_range(0, GAIN_MAX), count);
    endtask

    function automatic int pick_coef();
        return int'($urandom_range(0, 2 * COEF_MAX + 1)) + COEF_MIN;
    endfunction

    // sink side: random stalls, one long hold once the source is busy
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (!hold_done && sent_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // end the run if no transfer happens for too long
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_biquad_bandpass_filter_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus
    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.sample_in      = '0;
        in_ch.start_of_block = 1'b0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset coefficients: full-scale steps, sign edges, start of block
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh0000, 1'b0);

        // runaway filter: stored output saturates both ways, output clips
        drain_filter();
        program_filter(COEF_MAX, COEF_MIN, COEF_MIN, GAIN_MAX);
        send_sample(16'sh7FFF, 1'b1);
        repeat (6) send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        repeat (6) send_sample(16'sh8000, 1'b0);

        // reset values written back, no idling on either side
        calm = 1'b1;
        run_phase(int'(RST_COEF_B0), int'(RST_COEF_A1), int'(RST_COEF_A2),
                  int'(RST_OUT_GAIN), 200);
        calm = 1'b0;

        run_stable_phase(250);
        run_phase(COEF_MIN, COEF_MAX, COEF_MAX, GAIN_MAX, 150);
        run_phase(pick_coef(), pick_coef(), pick_coef(), 0, 100);
        repeat (4) run_stable_phase(200);
        run_phase(pick_coef(), pick_coef(), pick_coef(), $urandom_range(0, GAIN_MAX), 150);

        drain_filter();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("tb_biquad_bandpass_filter_top: done, clean");
        end else begin
            $display("tb_biquad_bandpass_filter_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bbf_pkg.sv
hw/rtl/bbf_in_if.sv
hw/rtl/bbf_out_if.sv
hw/rtl/bbf_ctrl.sv
hw/rtl/bbf_dp.sv
hw/rtl/biquad_bandpass_filter_top.sv
tb/biquad_output_checker.sv
tb/tb_biquad_bandpass_filter_top.sv
